// ----- src/quoted_escape_tokenizer_unit_assert.svh -----
// Assertion macros for the quoted escape tokenizer.
`ifndef QUOTED_ESCAPE_TOKENIZER_UNIT_ASSERT_SVH
`define QUOTED_ESCAPE_TOKENIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define QET_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qet assertion failed");
`define QET_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qet assertion failed");
`else
`define QET_ASSERT_NOW(label, ante, cons)
`define QET_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/qet_pkg.sv -----
// Shared types and constants of the quoted escape tokenizer.
`default_nettype none
package qet_pkg;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_END    = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_OPEN_SQ = 3'd1,
      ERR_OPEN_DQ = 3'd2,
      ERR_ESCAPE  = 3'd3,
      ERR_HEX     = 3'd4
   } err_type;

   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_HT     = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LA     = 8'h61;
   localparam logic [7:0] CHAR_LF_HEX = 8'h66;
   localparam logic [7:0] CHAR_UA     = 8'h41;
   localparam logic [7:0] CHAR_UF_HEX = 8'h46;
   localparam logic [7:0] HEX_ALPHA   = 8'd10;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic        byte_vld;
      logic [7:0]  byte_val;
      logic        end_vld;
      logic        stat_vld;
      logic [7:0]  total;
      err_type     err;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage
`default_nettype wire

// ----- src/qet_req_if.sv -----
// Input channel: one line byte per beat.
`default_nettype none
interface qet_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       line_end;

   modport source (output valid, output data_byte, output byte_present, output line_end,
                   input ready);
   modport sink (input valid, input data_byte, input byte_present, input line_end,
                 output ready);
endinterface
`default_nettype wire

// ----- src/qet_rsp_if.sv -----
// Result channel: one token byte, token end or line status per beat.
`default_nettype none
interface qet_rsp_if;
   logic              valid;
   logic              ready;
   qet_pkg::kind_type result_kind;
   logic [7:0]        token_byte;
   logic [7:0]        token_total;
   logic [2:0]        error_code;
   logic              last;

   modport source (output valid, output result_kind, output token_byte, output token_total,
                   output error_code, output last, input ready);
   modport sink (input valid, input result_kind, input token_byte, input token_total,
                 input error_code, input last, output ready);
endinterface
`default_nettype wire

// ----- src/qet_front.sv -----
// Front end: lexer state machine, classifies each byte into a result bundle.
`default_nettype none
module qet_front #(
   parameter int COUNT_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   qet_req_if.sink          req,
   input  wire logic        full,
   output qet_pkg::push_type push
);

   typedef enum logic [6:0] {
      MODE_BETWEEN = 7'b0000001,
      MODE_BARE    = 7'b0000010,
      MODE_SQ      = 7'b0000100,
      MODE_DQ      = 7'b0001000,
      MODE_ESC     = 7'b0010000,
      MODE_HEX1    = 7'b0100000,
      MODE_HEX2    = 7'b1000000
   } mode_type;

   localparam int WIDE = COUNT_BITS + 8;

   mode_type              mode_ff, mode_in;
   logic                  esc_q_ff, esc_q_in;
   logic [3:0]            hex_ff, hex_in;
   logic                  started_ff, started_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   qet_pkg::err_type      err_ff, err_in;

   logic                  fire;
   logic [7:0]            c;
   logic                  ws;
   logic [4:0]            hex_dig;
   logic                  do_bare;
   logic                  byte_vld;
   logic [7:0]            byte_val;
   logic                  bend;
   logic                  eend;
   logic                  stat;
   qet_pkg::err_type      serr;
   logic [COUNT_BITS-1:0] cnt_v;
   logic [WIDE-1:0]       cnt_wide;
   logic [7:0]            total;

   function automatic logic [4:0] hex_of(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'd0;
      if (ch >= qet_pkg::CHAR_ZERO && ch <= qet_pkg::CHAR_NINE) begin
         r = {1'b1, 4'(ch - qet_pkg::CHAR_ZERO)};
      end else if (ch >= qet_pkg::CHAR_LA && ch <= qet_pkg::CHAR_LF_HEX) begin
         r = {1'b1, 4'(ch - qet_pkg::CHAR_LA + qet_pkg::HEX_ALPHA)};
      end else if (ch >= qet_pkg::CHAR_UA && ch <= qet_pkg::CHAR_UF_HEX) begin
         r = {1'b1, 4'(ch - qet_pkg::CHAR_UA + qet_pkg::HEX_ALPHA)};
      end
      return r;
   endfunction

   assign req.ready = !full;
   assign fire      = req.valid && req.ready;
   assign c         = req.data_byte;
   assign ws        = (c == qet_pkg::CHAR_SPACE) || (c >= qet_pkg::CHAR_HT && c <= qet_pkg::CHAR_CR);
   assign hex_dig   = hex_of(c);

   always_comb begin
      mode_in    = mode_ff;
      esc_q_in   = esc_q_ff;
      hex_in     = hex_ff;
      started_in = started_ff;
      err_in     = err_ff;
      do_bare    = 1'b0;
      byte_vld   = 1'b0;
      byte_val   = 8'd0;
      bend       = 1'b0;
      eend       = 1'b0;
      stat       = 1'b0;
      serr       = qet_pkg::ERR_NONE;

      if (req.byte_present && err_ff == qet_pkg::ERR_NONE) begin
         unique case (mode_ff)
            MODE_BARE: begin
               if (ws) begin
                  bend       = 1'b1;
                  started_in = 1'b0;
                  mode_in    = MODE_BETWEEN;
               end else begin
                  do_bare = 1'b1;
               end
            end
            MODE_SQ: begin
               if (c == qet_pkg::CHAR_SQUOTE) begin
                  mode_in = MODE_BARE;
               end else begin
                  byte_vld = 1'b1;
                  byte_val = c;
               end
            end
            MODE_DQ: begin
               if (c == qet_pkg::CHAR_DQUOTE) begin
                  mode_in = MODE_BARE;
               end else if (c == qet_pkg::CHAR_BSLASH) begin
                  esc_q_in = 1'b1;
                  mode_in  = MODE_ESC;
               end else begin
                  byte_vld = 1'b1;
                  byte_val = c;
               end
            end
            MODE_ESC: begin
               if (c == qet_pkg::CHAR_X) begin
                  mode_in = MODE_HEX1;
               end else begin
                  byte_vld = 1'b1;
                  priority case (c)
                     qet_pkg::CHAR_N:    byte_val = qet_pkg::CHAR_LF;
                     qet_pkg::CHAR_R:    byte_val = qet_pkg::CHAR_CR;
                     qet_pkg::CHAR_T:    byte_val = qet_pkg::CHAR_HT;
                     qet_pkg::CHAR_ZERO: byte_val = qet_pkg::CHAR_NUL;
                     default:            byte_val = c;
                  endcase
                  mode_in = esc_q_ff ? MODE_DQ : MODE_BARE;
               end
            end
            MODE_HEX1: begin
               if (!hex_dig[4]) begin
                  err_in = qet_pkg::ERR_HEX;
               end else begin
                  hex_in  = hex_dig[3:0];
                  mode_in = MODE_HEX2;
               end
            end
            MODE_HEX2: begin
               if (!hex_dig[4]) begin
                  err_in = qet_pkg::ERR_HEX;
               end else begin
                  byte_vld = 1'b1;
                  byte_val = {hex_ff, hex_dig[3:0]};
                  mode_in  = esc_q_ff ? MODE_DQ : MODE_BARE;
               end
            end
            MODE_BETWEEN: begin
               if (!ws) begin
                  started_in = 1'b1;
                  mode_in    = MODE_BARE;
                  do_bare    = 1'b1;
               end
            end
            default: begin
            end
         endcase

         if (do_bare) begin
            if (c == qet_pkg::CHAR_SQUOTE) begin
               mode_in = MODE_SQ;
            end else if (c == qet_pkg::CHAR_DQUOTE) begin
               mode_in = MODE_DQ;
            end else if (c == qet_pkg::CHAR_BSLASH) begin
               esc_q_in = 1'b0;
               mode_in  = MODE_ESC;
            end else begin
               byte_vld = 1'b1;
               byte_val = c;
            end
         end
      end

      if (req.line_end) begin
         stat = 1'b1;
         serr = err_in;
         if (err_in == qet_pkg::ERR_NONE) begin
            if (mode_in == MODE_SQ) begin
               serr = qet_pkg::ERR_OPEN_SQ;
            end else if (mode_in == MODE_DQ) begin
               serr = qet_pkg::ERR_OPEN_DQ;
            end else if (mode_in == MODE_ESC || mode_in == MODE_HEX1 || mode_in == MODE_HEX2) begin
               serr = qet_pkg::ERR_ESCAPE;
            end else if (mode_in == MODE_BARE && started_in) begin
               eend = 1'b1;
            end
         end
      end

      cnt_v = count_ff;
      if ((bend || eend) && count_ff != {COUNT_BITS{1'b1}}) begin
         cnt_v = count_ff + 1'b1;
      end
      count_in = cnt_v;

      if (req.line_end) begin
         mode_in    = MODE_BETWEEN;
         esc_q_in   = 1'b0;
         hex_in     = 4'd0;
         started_in = 1'b0;
         count_in   = '0;
         err_in     = qet_pkg::ERR_NONE;
      end
   end

   assign cnt_wide = WIDE'(cnt_v);
   assign total    = (cnt_wide > WIDE'(255)) ? 8'hFF : cnt_wide[7:0];

   assign push.valid          = fire && (byte_vld || bend || eend || stat);
   assign push.entry.byte_vld = byte_vld;
   assign push.entry.byte_val = byte_val;
   assign push.entry.end_vld  = bend || eend;
   assign push.entry.stat_vld = stat;
   assign push.entry.total    = stat ? total : 8'd0;
   assign push.entry.err      = serr;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_BETWEEN;
         esc_q_ff   <= 1'b0;
         hex_ff     <= 4'd0;
         started_ff <= 1'b0;
         count_ff   <= '0;
         err_ff     <= qet_pkg::ERR_NONE;
      end else if (fire) begin
         mode_ff    <= mode_in;
         esc_q_ff   <= esc_q_in;
         hex_ff     <= hex_in;
         started_ff <= started_in;
         count_ff   <= count_in;
         err_ff     <= err_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/qet_queue.sv -----
// Short queue of result bundles between front and back.
`default_nettype none
module qet_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire qet_pkg::push_type push,
   output logic               full,
   output qet_pkg::head_type  head,
   input  wire logic          pop
);

   qet_pkg::entry_type              slot_ff [qet_pkg::QUEUE_DEPTH];
   logic [qet_pkg::QUEUE_AW-1:0]    wr_ff, wr_in;
   logic [qet_pkg::QUEUE_AW-1:0]    rd_ff, rd_in;
   logic [qet_pkg::QUEUE_AW:0]      used_ff, used_in;
   logic                            do_push;
   logic                            do_pop;

   assign full       = (used_ff == (qet_pkg::QUEUE_AW + 1)'(qet_pkg::QUEUE_DEPTH));
   assign head.valid = (used_ff != '0);
   assign head.entry = slot_ff[rd_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_in   = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;
      used_in = used_ff;
      if (do_push && !do_pop) begin
         used_in = used_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         used_in = used_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         used_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         used_ff <= used_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/qet_back.sv -----
// Back end: unpacks each bundle into result beats, marks the last one.
`default_nettype none
module qet_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire qet_pkg::head_type head,
   output logic               pop,
   qet_rsp_if.source          rsp
);

   logic byte_done_ff, byte_done_in;
   logic end_done_ff, end_done_in;
   logic sel_byte;
   logic sel_end;
   logic sel_stat;
   logic is_last;
   logic fire;

   assign sel_byte = head.entry.byte_vld && !byte_done_ff;
   assign sel_end  = !sel_byte && head.entry.end_vld && !end_done_ff;
   assign sel_stat = !sel_byte && !sel_end;
   assign is_last  = sel_stat || (sel_end && !head.entry.stat_vld)
                     || (sel_byte && !head.entry.end_vld && !head.entry.stat_vld);
   assign fire     = head.valid && rsp.ready;
   assign pop      = fire && is_last;

   assign rsp.valid       = head.valid;
   assign rsp.result_kind = sel_byte ? qet_pkg::KIND_BYTE
                          : (sel_end ? qet_pkg::KIND_END : qet_pkg::KIND_STATUS);
   assign rsp.token_byte  = sel_byte ? head.entry.byte_val : 8'd0;
   assign rsp.token_total = sel_stat ? head.entry.total : 8'd0;
   assign rsp.error_code  = sel_stat ? head.entry.err : qet_pkg::ERR_NONE;
   assign rsp.last        = is_last;

   always_comb begin
      byte_done_in = byte_done_ff;
      end_done_in  = end_done_ff;
      if (fire) begin
         if (is_last) begin
            byte_done_in = 1'b0;
            end_done_in  = 1'b0;
         end else if (sel_byte) begin
            byte_done_in = 1'b1;
         end else begin
            end_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_done_ff <= 1'b0;
         end_done_ff  <= 1'b0;
      end else begin
         byte_done_ff <= byte_done_in;
         end_done_ff  <= end_done_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/quoted_escape_tokenizer_unit.sv -----
// Top level of the quoted escape tokenizer.
// Shell-style line tokenizer. One byte beat is taken per cycle whenever the
// four-entry result queue has room; the lexer state machine in the front end
// turns each beat into a bundle of up to three results (token byte, token
// end, line status) in that same cycle. The back end sends one result beat
// per cycle while rsp.ready is high, so a beat that causes k results holds
// the output until all k are sent; once the queue fills, input throughput
// is set by the result count. Beats with no byte and no line end produce
// no result. After a bad hex digit, bytes are dropped until line end; the
// status reports the first error and the tokens ended before it. COUNT_BITS
// sets the saturating token counter; the reported total clips at 255.
`default_nettype none
`include "quoted_escape_tokenizer_unit_assert.svh"
module quoted_escape_tokenizer_unit #(
   parameter int COUNT_BITS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   qet_req_if.sink   req,
   qet_rsp_if.source rsp
);

   qet_pkg::push_type push;
   qet_pkg::head_type head;
   logic              full;
   logic              pop;

   qet_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .full (full),
      .push (push)
   );

   qet_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .full (full),
      .head (head),
      .pop  (pop)
   );

   qet_back u_back (
      .clock(clock),
      .reset(reset),
      .head (head),
      .pop  (pop),
      .rsp  (rsp)
   );

   `QET_ASSERT_NOW(a_no_overflow, push.valid, !full)
   `QET_ASSERT_NOW(a_status_last, rsp.valid && !rsp.last, rsp.result_kind != qet_pkg::KIND_STATUS)
   `QET_ASSERT_NEXT(a_more_follow, rsp.valid && rsp.ready && !rsp.last, rsp.valid)

endmodule
`default_nettype wire
